FILE: sv/mcr_pkg.sv
// ----------------------------------------------------------------------------
// mcr_pkg
// Shared types and constants for the magnetometer calibrate-and-rotate block.
// ----------------------------------------------------------------------------
package mcr_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_COUNT_SCALE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SOFT_ROW0   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SOFT_ROW1   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SOFT_ROW2   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ORIENT      = 3'd7;

  localparam logic [15:0] SCALE_RESET = 16'd6554;
  localparam logic [17:0] SOFT_ONE    = 18'sd32768;
  localparam logic [15:0] QUAT_ONE    = 16'd16384;
  localparam logic signed [29:0] R_ONE = 30'sd268435456;

  typedef logic signed [15:0] pt_t;
  typedef logic signed [17:0] soft_t;
  typedef logic signed [15:0] quat_t;
  // d: raw(16) * scale(17 signed) >> 12 minus offset: fits 22 bits
  typedef logic signed [21:0] diff_t;
  // matrix entry Q.28: |2 * q * q| <= 2^31, one - 2a^2 - 2b^2 down to ~ -2^32
  typedef logic signed [33:0] rot_t;

  function automatic pt_t sat16(input logic signed [47:0] v);
    if (v > 48'sd32767) return 16'sh7fff;
    else if (v < -48'sd32768) return 16'sh8000;
    else return v[15:0];
  endfunction

endpackage

FILE: sv/mag_calibrate_and_rotate.sv
// ----------------------------------------------------------------------------
// mag_calibrate_and_rotate
// Hard/soft-iron magnetometer calibration followed by a quaternion rotation.
// ----------------------------------------------------------------------------
// One sample per cycle enters a seven-stage pipeline: scale, offset, soft-iron
// products, soft-iron sum/round/saturate, rotation products, rotation sum,
// round/saturate. out_valid is the valid flag of the last stage; a stall at the
// output freezes every stage together. Samples with sample_valid low are dropped
// at the input. Rotation matrix entries are computed from the quaternion
// register in a two-stage side path that has no enable and ignores the output
// stall; the user must write configuration only while the pipeline is empty,
// and the block itself does not enforce this.
module mag_calibrate_and_rotate (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  mcr_pkg::pt_t                  in_raw_x,
  input  mcr_pkg::pt_t                  in_raw_y,
  input  mcr_pkg::pt_t                  in_raw_z,
  input  logic                          in_sample_valid,
  output logic                          out_valid,
  input  logic                          out_stall,
  output mcr_pkg::pt_t                  out_cal_x,
  output mcr_pkg::pt_t                  out_cal_y,
  output mcr_pkg::pt_t                  out_cal_z,
  output mcr_pkg::pt_t                  out_rot_x,
  output mcr_pkg::pt_t                  out_rot_y,
  output mcr_pkg::pt_t                  out_rot_z,
  output logic                          out_front_facing,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mcr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mcr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mcr_pkg::*;

  localparam int NS = 7;

  logic [15:0] scale_r;
  pt_t         off_r [3];
  soft_t       m_r [3][3];
  quat_t       q_r [4];
  rot_t        rm_r [9];
  logic signed [31:0] qp_r [10];

  logic        adv;
  logic [NS-1:0] v_r;

  assign cfg_ready = 1'b1;
  assign adv = !(v_r[NS-1] && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
      for (int i = 0; i < 3; i++) begin
        off_r[i] <= '0;
        for (int j = 0; j < 3; j++) m_r[i][j] <= (i == j) ? SOFT_ONE : '0;
      end
      q_r[0] <= QUAT_ONE;
      q_r[1] <= '0;
      q_r[2] <= '0;
      q_r[3] <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_COUNT_SCALE: scale_r <= cfg_data[15:0];
        REG_OFFSET_X: off_r[0] <= cfg_data[15:0];
        REG_OFFSET_Y: off_r[1] <= cfg_data[15:0];
        REG_OFFSET_Z: off_r[2] <= cfg_data[15:0];
        REG_SOFT_ROW0: for (int k = 0; k < 3; k++) m_r[0][k] <= cfg_data[18*k +: 18];
        REG_SOFT_ROW1: for (int k = 0; k < 3; k++) m_r[1][k] <= cfg_data[18*k +: 18];
        REG_SOFT_ROW2: for (int k = 0; k < 3; k++) m_r[2][k] <= cfg_data[18*k +: 18];
        REG_ORIENT: for (int k = 0; k < 4; k++) q_r[k] <= cfg_data[16*k +: 16];
        default: ;
      endcase
    end
  end

  // rotation matrix side path; z is -q3 at 17 bits
  logic signed [16:0] qw, qx, qy, qz;
  assign qw = 17'(q_r[0]);
  assign qx = 17'(q_r[1]);
  assign qy = 17'(q_r[2]);
  assign qz = -17'(q_r[3]);

  always_ff @(posedge clk) begin
    qp_r[0] <= 32'(qy * qy);
    qp_r[1] <= 32'(qz * qz);
    qp_r[2] <= 32'(qx * qx);
    qp_r[3] <= 32'(qx * qy);
    qp_r[4] <= 32'(qz * qw);
    qp_r[5] <= 32'(qx * qz);
    qp_r[6] <= 32'(qy * qw);
    qp_r[7] <= 32'(qy * qz);
    qp_r[8] <= 32'(qx * qw);
    qp_r[9] <= '0;
    rm_r[0] <= 34'(R_ONE) - 34'(qp_r[0]) * 2 - 34'(qp_r[1]) * 2;
    rm_r[1] <= 34'(qp_r[3]) * 2 - 34'(qp_r[4]) * 2;
    rm_r[2] <= 34'(qp_r[5]) * 2 + 34'(qp_r[6]) * 2;
    rm_r[3] <= 34'(qp_r[3]) * 2 + 34'(qp_r[4]) * 2;
    rm_r[4] <= 34'(R_ONE) - 34'(qp_r[2]) * 2 - 34'(qp_r[1]) * 2 + 34'(qp_r[9]);
    rm_r[5] <= 34'(qp_r[7]) * 2 - 34'(qp_r[8]) * 2;
    rm_r[6] <= 34'(qp_r[5]) * 2 - 34'(qp_r[6]) * 2;
    rm_r[7] <= 34'(qp_r[7]) * 2 + 34'(qp_r[8]) * 2;
    rm_r[8] <= 34'(R_ONE) - 34'(qp_r[2]) * 2 - 34'(qp_r[0]) * 2;
  end

  // datapath registers
  logic signed [33:0] s1_r [3];
  diff_t              s2_r [3];
  logic signed [39:0] s3_r [3][3];
  pt_t                s4_r [3];
  logic signed [49:0] s5_r [3][3];
  logic signed [51:0] s6_r [3];
  pt_t                c5_r [3], c6_r [3];
  pt_t                cal_r [3], rot_r [3];

  pt_t raw_in [3];
  assign raw_in[0] = in_raw_x;
  assign raw_in[1] = in_raw_y;
  assign raw_in[2] = in_raw_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NS-2:0], in_valid && in_sample_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s1_r[i] <= 34'(raw_in[i] * $signed({1'b0, scale_r})) + 34'sd2048;
        s2_r[i] <= 22'(s1_r[i] >>> 12) - 22'(off_r[i]);
        for (int j = 0; j < 3; j++) s3_r[i][j] <= 40'(s2_r[j] * m_r[i][j]);
        s4_r[i] <= sat16(48'((s3_r[i][0] + s3_r[i][1] + s3_r[i][2]
                           + 40'sd16384) >>> 15));
        for (int j = 0; j < 3; j++) s5_r[i][j] <= 50'(s4_r[j] * rm_r[3*i+j]);
        c5_r[i] <= s4_r[i];
        s6_r[i] <= 52'(s5_r[i][0]) + 52'(s5_r[i][1]) + 52'(s5_r[i][2])
                   + 52'sd134217728;
        c6_r[i] <= c5_r[i];
        rot_r[i] <= sat16(48'(s6_r[i] >>> 28));
        cal_r[i] <= c6_r[i];
      end
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_cal_x = cal_r[0];
  assign out_cal_y = cal_r[1];
  assign out_cal_z = cal_r[2];
  assign out_rot_x = rot_r[0];
  assign out_rot_y = rot_r[1];
  assign out_rot_z = rot_r[2];
  assign out_front_facing = !rot_r[1][15];

endmodule

FILE: sv/mcr_checker.sv
// ----------------------------------------------------------------------------
// mcr_checker
// Port-level checks on the calibrate-and-rotate block.
// ----------------------------------------------------------------------------
module mcr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_rot_y,
  input logic [15:0] out_cal_x,
  input logic        out_front_facing,
  input logic        cfg_ready
);
  a_ff: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_front_facing == !out_rot_y[15])) else $error("front flag");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall)) else $error("stall without backpressure");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_cal_x)))
    else $error("stalled transaction changed");
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready) else $error("config not ready");
endmodule

bind mag_calibrate_and_rotate mcr_checker u_mcr_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_rot_y(out_rot_y),
  .out_cal_x(out_cal_x), .out_front_facing(out_front_facing), .cfg_ready(cfg_ready)
);

FILE: tb/mag_calibrate_and_rotate_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mag_calibrate_and_rotate_tb
// Drives raw magnetometer samples through the calibrate-and-rotate block under
// several register settings, with random gaps on both sides. Each output
// transaction is compared field by field with an internal fixed-point model.
// ----------------------------------------------------------------------------
module mag_calibrate_and_rotate_tb;
  import mcr_pkg::*;

  typedef struct {
    logic signed [15:0] cx, cy, cz, rx, ry, rz;
    logic ff;
  } mag_res_t;

  typedef struct {
    logic signed [15:0] x, y, z;
    logic sv;
    logic chk;
    logic signed [15:0] ex, ey, ez;
  } stim_row_t;

  logic clk, rst_n;
  logic in_valid, in_stall, in_sample_valid;
  pt_t in_raw_x, in_raw_y, in_raw_z;
  logic out_valid, out_stall, out_front_facing;
  pt_t out_cal_x, out_cal_y, out_cal_z, out_rot_x, out_rot_y, out_rot_z;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mag_calibrate_and_rotate uut (.*);

  // model copy of the registers
  longint m_scale;
  longint m_off[3];
  longint m_soft[3][3];
  longint m_quat[4];

  mag_res_t expected_q[$];
  int err_count = 0;
  int gap_left = 0;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Test completed with failures");
    $finish;
  end

  function automatic longint sx(longint v, int w);
    longint m;
    m = (longint'(1) << w) - 1;
    v = v & m;
    return v[w-1] ? (v | ~m) : v;
  endfunction

  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic void model_write(logic [2:0] idx, logic [63:0] v);
    case (idx)
      REG_COUNT_SCALE: m_scale = longint'(v[15:0]);
      REG_OFFSET_X: m_off[0] = sx(v, 16);
      REG_OFFSET_Y: m_off[1] = sx(v, 16);
      REG_OFFSET_Z: m_off[2] = sx(v, 16);
      REG_SOFT_ROW0, REG_SOFT_ROW1, REG_SOFT_ROW2:
        for (int k = 0; k < 3; k++) m_soft[idx - REG_SOFT_ROW0][k] = sx(v >> (18 * k), 18);
      REG_ORIENT: for (int k = 0; k < 4; k++) m_quat[k] = sx(v >> (16 * k), 16);
      default: ;
    endcase
  endfunction

  function automatic mag_res_t calibrate_rotate(longint rx, longint ry, longint rz);
    mag_res_t r;
    longint raw[3], d[3], c[3], o[3], rm[9];
    longint w, x, y, z, one;
    raw[0] = rx; raw[1] = ry; raw[2] = rz;
    for (int i = 0; i < 3; i++) d[i] = rnd_shift(raw[i] * m_scale, 12) - m_off[i];
    for (int i = 0; i < 3; i++)
      c[i] = clip16(rnd_shift(d[0] * m_soft[i][0] + d[1] * m_soft[i][1]
                              + d[2] * m_soft[i][2], 15));
    w = m_quat[0]; x = m_quat[1]; y = m_quat[2]; z = -m_quat[3];
    one = longint'(1) << 28;
    rm[0] = one - 2*y*y - 2*z*z; rm[1] = 2*x*y - 2*z*w; rm[2] = 2*x*z + 2*y*w;
    rm[3] = 2*x*y + 2*z*w; rm[4] = one - 2*x*x - 2*z*z; rm[5] = 2*y*z - 2*x*w;
    rm[6] = 2*x*z - 2*y*w; rm[7] = 2*y*z + 2*x*w; rm[8] = one - 2*x*x - 2*y*y;
    for (int i = 0; i < 3; i++)
      o[i] = clip16(rnd_shift(c[0] * rm[3*i] + c[1] * rm[3*i+1] + c[2] * rm[3*i+2], 28));
    r.cx = 16'(c[0]); r.cy = 16'(c[1]); r.cz = 16'(c[2]);
    r.rx = 16'(o[0]); r.ry = 16'(o[1]); r.rz = 16'(o[2]);
    r.ff = (o[1] >= 0);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // result side: random stall and compare
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected transaction", 0, 0);
        end else begin
          mag_res_t e;
          e = expected_q.pop_front();
          if (out_cal_x !== e.cx) report_mismatch("cal_x", out_cal_x, e.cx);
          if (out_cal_y !== e.cy) report_mismatch("cal_y", out_cal_y, e.cy);
          if (out_cal_z !== e.cz) report_mismatch("cal_z", out_cal_z, e.cz);
          if (out_rot_x !== e.rx) report_mismatch("rot_x", out_rot_x, e.rx);
          if (out_rot_y !== e.ry) report_mismatch("rot_y", out_rot_y, e.ry);
          if (out_rot_z !== e.rz) report_mismatch("rot_z", out_rot_z, e.rz);
          if (out_front_facing !== e.ff)
            report_mismatch("front_facing", out_front_facing, e.ff);
        end
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        out_stall <= 1'b1;
      end else if (out_valid && !out_stall || !out_valid) begin
        int g;
        g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
        gap_left <= (g > 0) ? g - 1 : 0;
        out_stall <= (g != 0);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [63:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    model_write(idx, v);
  endtask

  task automatic wait_drained();
    int n;
    n = 0;
    while (expected_q.size() != 0) @(posedge clk);
    while (n < 12) begin
      @(posedge clk);
      n++;
    end
  endtask

  // in_valid is held high across back-to-back samples
  task automatic send_sample(logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z, logic sv, bit last_gap);
    int g;
    g = last_gap ? 0 : $urandom_range(0, 5);
    if ($urandom_range(0, 2) == 0) g = 0;
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_raw_x <= x; in_raw_y <= y; in_raw_z <= z;
    in_sample_valid <= sv;
    do @(posedge clk); while (in_stall);
    if (sv) expected_q.push_back(calibrate_rotate(x, y, z));
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [53:0] pack_row(longint a, longint b, longint c);
    return {c[17:0], b[17:0], a[17:0]};
  endfunction

  function automatic logic [63:0] pack_quat(longint a, longint b, longint c, longint d);
    return {d[15:0], c[15:0], b[15:0], a[15:0]};
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      logic signed [15:0] x, y, z;
      int mode;
      mode = $urandom_range(0, 9);
      x = 16'($urandom); y = 16'($urandom); z = 16'($urandom);
      if (mode < 5) begin
        x = $signed(x) >>> $urandom_range(4, 12);
        y = $signed(y) >>> $urandom_range(4, 12);
        z = $signed(z) >>> $urandom_range(4, 12);
      end
      send_sample(x, y, z, ($urandom_range(0, 7) != 0), 0);
    end
    idle_input();
  endtask

  stim_row_t directed[] = '{
    '{0, 0, 0, 1, 1, 0, 0, 0},
    '{10, -10, 20, 1, 1, 16, -16, 32},
    '{32767, 32767, 32767, 1, 1, 32767, 32767, 32767},
    '{-32768, -32768, -32768, 1, 1, -32768, -32768, -32768},
    '{32767, -32768, 0, 1, 1, 32767, -32768, 0},
    '{5, 5, 5, 0, 0, 0, 0, 0},
    '{-1, 1, -1, 1, 0, 0, 0, 0},
    '{16'h5555, 16'haaaa, 16'h0f0f, 1, 0, 0, 0, 0},
    '{16'haaaa, 16'h5555, 16'hf0f0, 1, 0, 0, 0, 0},
    '{-32768, 32767, -32768, 0, 0, 0, 0, 0},
    '{1000, -2000, 3000, 1, 0, 0, 0, 0}
  };

  initial begin
    rst_n = 0;
    in_valid = 0; in_raw_x = 0; in_raw_y = 0; in_raw_z = 0; in_sample_valid = 0;
    cfg_valid = 0; cfg_index = 0; cfg_data = 0;
    model_write(REG_COUNT_SCALE, 64'd6554);
    for (int i = 0; i < 3; i++) m_off[i] = 0;
    model_write(REG_SOFT_ROW0, 64'd32768);
    model_write(REG_SOFT_ROW1, 64'd8589934592);
    model_write(REG_SOFT_ROW2, 64'd2251799813685248);
    model_write(REG_ORIENT, 64'd16384);
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // reset settings: directed table
    foreach (directed[i]) begin
      send_sample(directed[i].x, directed[i].y, directed[i].z, directed[i].sv, 0);
      if (directed[i].chk) begin
        mag_res_t e;
        e = expected_q[$];
        if (e.cx !== directed[i].ex || e.cy !== directed[i].ey || e.cz !== directed[i].ez)
          report_mismatch("directed table row", i, 0);
      end
    end
    idle_input();
    wait_drained();

    // extreme settings: full scale, offsets at +max, -max and +1, large matrix, odd quaternion
    cfg_write(REG_COUNT_SCALE, 64'hffff);
    cfg_write(REG_OFFSET_X, 64'h7fff);
    cfg_write(REG_OFFSET_Y, 64'h8000);
    cfg_write(REG_OFFSET_Z, 64'hffff_ffff_ffff_0001);
    cfg_write(REG_SOFT_ROW0, 64'(pack_row(131071, -131072, 1)));
    cfg_write(REG_SOFT_ROW1, 64'(pack_row(-131072, 131071, -1)));
    cfg_write(REG_SOFT_ROW2, {10'h3ff, pack_row(0, 0, 131071)});
    cfg_write(REG_ORIENT, pack_quat(-32768, 32767, -32768, -32768));
    for (int i = 0; i < 8; i++)
      send_sample(16'($urandom), 16'($urandom), 16'($urandom), 1, 0);
    send_sample(32767, 32767, 32767, 1, 0);
    send_sample(-32768, -32768, -32768, 1, 0);
    idle_input();
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      cfg_write(REG_COUNT_SCALE, (ph == 0) ? 64'd0 : 64'($urandom_range(0, 65535)));
      cfg_write(REG_OFFSET_X, {$urandom, $urandom});
      cfg_write(REG_OFFSET_Y, 64'($urandom_range(0, 65535)));
      cfg_write(REG_OFFSET_Z, 64'($urandom_range(0, 65535)));
      if (ph % 2 == 0) begin
        cfg_write(REG_SOFT_ROW0, 64'(pack_row(32768 + $urandom_range(0, 4000) - 2000,
                                              $urandom_range(0, 4000) - 2000,
                                              $urandom_range(0, 4000) - 2000)));
        cfg_write(REG_SOFT_ROW1, {$urandom, $urandom});
        cfg_write(REG_SOFT_ROW2, 64'(pack_row($urandom_range(0, 4000) - 2000, 1000,
                                              30000 + $urandom_range(0, 5000))));
        // near-unit quaternion
        cfg_write(REG_ORIENT, pack_quat(11585, 0, 0, (ph == 2) ? -11585 : 11585));
      end else begin
        cfg_write(REG_SOFT_ROW0, {$urandom, $urandom});
        cfg_write(REG_SOFT_ROW2, {$urandom, $urandom});
        cfg_write(REG_ORIENT, {$urandom, $urandom});
      end
      cfg_write(REG_ORIENT, (ph == 5) ? 64'd16384 : pack_quat(
                $urandom_range(0, 32767) - 16384, $urandom_range(0, 16384) - 8192,
                $urandom_range(0, 16384) - 8192, $urandom_range(0, 16384) - 8192));
      random_phase(190);
      wait_drained();
    end

    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

FILE: mag_calibrate_and_rotate.f
sv/mcr_pkg.sv
sv/mag_calibrate_and_rotate.sv
sv/mcr_checker.sv
tb/mag_calibrate_and_rotate_tb.sv
